// File: rtl/core/moving_average_convergence_detect_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the moving average convergence detector
// Concurrent assertion wrappers; they compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_CONVERGENCE_DETECT_MACROS_SVH
`define MOVING_AVERAGE_CONVERGENCE_DETECT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge out of reset
`define MACD_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define MACD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MACD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MACD_ASSERT(label, clk, rst_n, cond, msg)
`define MACD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MACD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/core/macd_pkg.sv
// ----------------------------------------------------------------------------
// macd_pkg
// Widths, reset values, register indexes and state codes of the detector.
// ----------------------------------------------------------------------------
package macd_pkg;

    // default sizes
    localparam int unsigned MAX_WINDOW_DEF = 64;
    localparam int unsigned MAX_GENES_DEF  = 65536;

    // field and datapath widths
    localparam int unsigned FIT_W    = 32;
    localparam int unsigned TOTAL_W  = 48;
    localparam int unsigned MEAN_W   = 48;
    localparam int unsigned PERIOD_W = 7;
    localparam int unsigned WTOT_W   = MEAN_W + PERIOD_W;  // up to 127 means of 48 bits
    localparam int unsigned COEF_W   = 32;
    localparam int unsigned RUN_W    = 16;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned IDX_W    = 1;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned DVD_W    = 64;   // dividend / quotient shift register
    localparam int unsigned DVS_W    = 48;   // divisor and partial remainder
    localparam int unsigned DCNT_W   = $clog2(DVD_W + 1);
    localparam int unsigned OUT_W    = COEF_W + MEAN_W;

    // reset and saturation values
    localparam logic [PERIOD_W-1:0]      PERIOD_RST   = 7'd10;
    localparam logic signed [COEF_W-1:0] MIN_COEF_RST = 32'sd65536;
    localparam logic signed [COEF_W-1:0] COEF_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0] COEF_MIN     = 32'sh8000_0000;
    localparam logic signed [MEAN_W-1:0] MEAN_MAX     = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [MEAN_W-1:0] MEAN_MIN     = 48'sh8000_0000_0000;
    localparam logic [RUN_W-1:0]         RUN_MAX      = 16'hFFFF;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_WINDOW_PERIOD   = 1'b0,
        REG_MIN_COEFFICIENT = 1'b1
    } t_reg_idx;

    // sequencer states
    typedef enum logic [12:0] {
        S_IDLE      = 13'b0_0000_0000_0001,
        S_MEAN_LD   = 13'b0_0000_0000_0010,
        S_MEAN_DIV  = 13'b0_0000_0000_0100,
        S_MEAN_SAT  = 13'b0_0000_0000_1000,
        S_WIN_UPD   = 13'b0_0000_0001_0000,
        S_WIN_ADD   = 13'b0_0000_0010_0000,
        S_AVG_LD    = 13'b0_0000_0100_0000,
        S_AVG_DIV   = 13'b0_0000_1000_0000,
        S_RATIO_LD  = 13'b0_0001_0000_0000,
        S_RATIO_DIV = 13'b0_0010_0000_0000,
        S_RATIO_SAT = 13'b0_0100_0000_0000,
        S_CMP       = 13'b0_1000_0000_0000,
        S_DONE      = 13'b1_0000_0000_0000
    } t_state;

endpackage

// File: rtl/core/macd_ram.sv
// ----------------------------------------------------------------------------
// macd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module macd_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/moving_average_convergence_detect.sv
// ----------------------------------------------------------------------------
// moving_average_convergence_detect
// Per-generation mean of gene fitness, sliding window of generation means,
// Q16.16 ratio of the newest mean to the window mean and a below-threshold
// run counter that flags convergence.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Payload                                      Transfer when
// -------  ---  -------------------------------------------  ----------------
// s_axis   in   tdata = fitness, tlast = last_gene           tvalid & tready
// m_axis   out  tdata = coefficient, generation_mean;        tvalid & tready
//               tuser = converged
// cfg      in   idx 0 = window_period, idx 1 = min_coefficient  we
//
// A gene without tlast adds to the sum; tready stays high while gene sums run.
// A gene with tlast runs up to three 64-step passes of the shared radix-2
// divider (generation mean, window mean, coefficient); tready stays low until
// the sequencer is back in idle. Only the mean pass runs while the window fills,
// and the coefficient pass is skipped when the window mean is zero.
// The result sits in an output register; the sequencer only waits on the
// m_axis side when a previous result has not been taken yet.
// Synchronous active-low reset; the window RAM is not cleared, only its fill
// count, so entries are never read before they are written.
//
`include "moving_average_convergence_detect_macros.svh"

module moving_average_convergence_detect #(
    parameter int unsigned MAX_WINDOW = macd_pkg::MAX_WINDOW_DEF,
    parameter int unsigned MAX_GENES  = macd_pkg::MAX_GENES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic [macd_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [macd_pkg::CFG_W-1:0]   i_cfg_data,
    // gene stream
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [macd_pkg::FIT_W-1:0]   i_s_axis_tdata,   // [31:0] fitness
    input  logic                         i_s_axis_tlast,   // last_gene
    // result stream
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [macd_pkg::OUT_W-1:0]   o_m_axis_tdata,   // [31:0] coefficient,
                                                           // [79:32] generation_mean
    output logic                         o_m_axis_tuser    // converged
);

    import macd_pkg::*;

    localparam int unsigned CW   = $clog2(MAX_GENES + 1);
    localparam int unsigned PW   = $clog2(MAX_WINDOW + 1);
    localparam int unsigned AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int unsigned CMPW = (PW > PERIOD_W) ? PW : PERIOD_W;

    // control state
    t_state                     r_state, n_state;
    logic [PERIOD_W-1:0]        r_period;
    logic signed [COEF_W-1:0]   r_min_coef;
    logic signed [TOTAL_W-1:0]  r_total;
    logic [CW-1:0]              r_count;
    logic [PW-1:0]              r_fill;
    logic [AW-1:0]              r_head;
    logic signed [WTOT_W-1:0]   r_wtotal;
    logic signed [COEF_W-1:0]   r_ratio;
    logic [RUN_W-1:0]           r_run;
    logic [DCNT_W-1:0]          r_div_cnt;
    logic                       r_out_valid;

    // datapath
    logic [DVD_W-1:0]           r_div_dq, n_div_dq;
    logic [DVS_W-1:0]           r_div_rem, n_div_rem;
    logic [DVS_W-1:0]           r_div_dvs;
    logic                       r_div_neg;
    logic                       r_zero_cnt;
    logic signed [MEAN_W-1:0]   r_mean;
    logic                       r_out_conv;
    logic signed [COEF_W-1:0]   r_out_coef;
    logic signed [MEAN_W-1:0]   r_out_mean;

    logic                       w_in_xfer;
    logic                       w_out_free;
    logic [PW-1:0]              w_period;
    logic signed [TOTAL_W:0]    w_gene_sum;
    logic signed [TOTAL_W-1:0]  n_total;
    logic [TOTAL_W-1:0]         w_total_mag;
    logic [WTOT_W-1:0]          w_wtotal_mag;
    logic [MEAN_W-1:0]          w_mean_mag;
    logic [DVS_W:0]             w_div_shift;
    logic [DVS_W+1:0]           w_div_diff;
    logic signed [MEAN_W-1:0]   w_mean_sat;
    logic signed [COEF_W-1:0]   w_ratio_sat;
    logic [DVS_W-1:0]           w_q_low;
    logic [PW:0]                w_slot_sum;
    logic [PW:0]                w_slot_wrap;
    logic [AW-1:0]              w_slot;
    logic [PW-1:0]              w_head_inc;
    logic [AW-1:0]              w_head_nxt;
    logic                       w_fill_open;
    logic                       w_ram_we;
    logic [AW-1:0]              w_ram_waddr;
    logic [MEAN_W-1:0]          w_ram_rdata;

    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_mean, r_out_coef};
    assign o_m_axis_tuser  = r_out_conv;

    // effective window period, clamped to 1..MAX_WINDOW
    always_comb begin
        if (r_period == '0) begin
            w_period = PW'(1);
        end else if (CMPW'(r_period) > CMPW'(MAX_WINDOW)) begin
            w_period = PW'(MAX_WINDOW);
        end else begin
            w_period = PW'(r_period);
        end
    end

    // saturating generation sum
    always_comb begin
        w_gene_sum = {r_total[TOTAL_W-1], r_total}
                   + {{(TOTAL_W + 1 - FIT_W){i_s_axis_tdata[FIT_W-1]}}, i_s_axis_tdata};
        if (w_gene_sum[TOTAL_W] != w_gene_sum[TOTAL_W-1]) begin
            n_total = w_gene_sum[TOTAL_W] ? MEAN_MIN : MEAN_MAX;
        end else begin
            n_total = w_gene_sum[TOTAL_W-1:0];
        end
    end

    // magnitudes for the divider
    assign w_total_mag  = r_total[TOTAL_W-1]  ? TOTAL_W'(-r_total)  : TOTAL_W'(r_total);
    assign w_wtotal_mag = r_wtotal[WTOT_W-1]  ? WTOT_W'(-r_wtotal)  : WTOT_W'(r_wtotal);
    assign w_mean_mag   = r_mean[MEAN_W-1]    ? MEAN_W'(-r_mean)    : MEAN_W'(r_mean);

    // restoring divider step: one quotient bit per cycle
    always_comb begin
        w_div_shift = {r_div_rem, r_div_dq[DVD_W-1]};
        w_div_diff  = {1'b0, w_div_shift} - {2'b00, r_div_dvs};
        if (!w_div_diff[DVS_W+1]) begin
            n_div_rem = w_div_diff[DVS_W-1:0];
            n_div_dq  = {r_div_dq[DVD_W-2:0], 1'b1};
        end else begin
            n_div_rem = w_div_shift[DVS_W-1:0];
            n_div_dq  = {r_div_dq[DVD_W-2:0], 1'b0};
        end
    end

    // quotient saturation to Q32.16 and Q16.16
    assign w_q_low = r_div_dq[DVS_W-1:0];

    always_comb begin
        if (!r_div_neg) begin
            w_mean_sat = (|r_div_dq[DVD_W-1:MEAN_W-1]) ? MEAN_MAX : r_div_dq[MEAN_W-1:0];
        end else if ((|r_div_dq[DVD_W-1:MEAN_W])
                  || (r_div_dq[MEAN_W-1] && (|r_div_dq[MEAN_W-2:0]))) begin
            w_mean_sat = MEAN_MIN;
        end else begin
            w_mean_sat = MEAN_W'(-r_div_dq[MEAN_W-1:0]);
        end
    end

    always_comb begin
        if (!r_div_neg) begin
            w_ratio_sat = (|r_div_dq[DVD_W-1:COEF_W-1]) ? COEF_MAX : r_div_dq[COEF_W-1:0];
        end else if ((|r_div_dq[DVD_W-1:COEF_W])
                  || (r_div_dq[COEF_W-1] && (|r_div_dq[COEF_W-2:0]))) begin
            w_ratio_sat = COEF_MIN;
        end else begin
            w_ratio_sat = COEF_W'(-r_div_dq[COEF_W-1:0]);
        end
    end

    // ring pointers
    always_comb begin
        w_fill_open = (r_fill < w_period);
        w_slot_sum  = (PW + 1)'(r_head) + (PW + 1)'(r_fill);
        w_slot_wrap = (w_slot_sum >= {1'b0, w_period})
                    ? (w_slot_sum - {1'b0, w_period}) : w_slot_sum;
        w_slot      = w_slot_wrap[AW-1:0];
        w_head_inc  = PW'(r_head) + PW'(1);
        w_head_nxt  = (w_head_inc == w_period) ? '0 : w_head_inc[AW-1:0];
        w_ram_we    = (r_state == S_WIN_UPD);
        w_ram_waddr = w_fill_open ? w_slot : r_head;
    end

    // window of generation means; the oldest entry is read at the head
    macd_ram #(
        .WIDTH (MEAN_W),
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (r_mean),
        .i_raddr (r_head),
        .o_rdata (w_ram_rdata)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (w_in_xfer && i_s_axis_tlast) n_state = S_MEAN_LD;
            S_MEAN_LD:   n_state = S_MEAN_DIV;
            S_MEAN_DIV:  if (r_div_cnt == DCNT_W'(1)) n_state = S_MEAN_SAT;
            S_MEAN_SAT:  n_state = S_WIN_UPD;
            S_WIN_UPD:   n_state = S_WIN_ADD;
            S_WIN_ADD:   n_state = (r_fill == w_period) ? S_AVG_LD : S_CMP;
            S_AVG_LD:    n_state = S_AVG_DIV;
            S_AVG_DIV:   if (r_div_cnt == DCNT_W'(1)) n_state = S_RATIO_LD;
            S_RATIO_LD:  n_state = (w_q_low == '0) ? S_CMP : S_RATIO_DIV;
            S_RATIO_DIV: if (r_div_cnt == DCNT_W'(1)) n_state = S_RATIO_SAT;
            S_RATIO_SAT: n_state = S_CMP;
            S_CMP:       n_state = S_DONE;
            S_DONE:      if (w_out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= PERIOD_RST;
            r_min_coef  <= MIN_COEF_RST;
            r_total     <= '0;
            r_count     <= '0;
            r_fill      <= '0;
            r_head      <= '0;
            r_wtotal    <= '0;
            r_ratio     <= COEF_MAX;
            r_run       <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // result register: loaded from the done state, emptied by a transfer
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer && (r_count < CW'(MAX_GENES))) begin
                        r_total <= n_total;
                        r_count <= r_count + CW'(1);
                    end
                end
                S_MEAN_LD: begin
                    r_total   <= '0;
                    r_count   <= '0;
                    r_div_cnt <= DCNT_W'(DVD_W);
                end
                S_MEAN_DIV, S_AVG_DIV, S_RATIO_DIV: begin
                    r_div_cnt <= r_div_cnt - DCNT_W'(1);
                end
                S_WIN_UPD: begin
                    if (w_fill_open) begin
                        r_fill <= r_fill + PW'(1);
                    end else begin
                        r_wtotal <= r_wtotal
                                  - {{(WTOT_W - MEAN_W){w_ram_rdata[MEAN_W-1]}}, w_ram_rdata};
                        r_head   <= w_head_nxt;
                    end
                end
                S_WIN_ADD: begin
                    r_wtotal <= r_wtotal + {{(WTOT_W - MEAN_W){r_mean[MEAN_W-1]}}, r_mean};
                end
                S_AVG_LD: begin
                    r_div_cnt <= DCNT_W'(DVD_W);
                end
                S_RATIO_LD: begin
                    if (w_q_low == '0) begin
                        r_ratio <= COEF_MAX;
                    end else begin
                        r_div_cnt <= DCNT_W'(DVD_W);
                    end
                end
                S_RATIO_SAT: begin
                    r_ratio <= w_ratio_sat;
                end
                S_CMP: begin
                    if (r_ratio < r_min_coef) begin
                        if (r_run != RUN_MAX) begin
                            r_run <= r_run + RUN_W'(1);
                        end
                    end else begin
                        r_run <= '0;
                    end
                end
                default: begin
                end
            endcase

            // configuration writes; a new period empties the window
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_WINDOW_PERIOD: begin
                        r_period <= i_cfg_data[PERIOD_W-1:0];
                        r_fill   <= '0;
                        r_head   <= '0;
                        r_wtotal <= '0;
                    end
                    REG_MIN_COEFFICIENT: begin
                        r_min_coef <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // divider operands and result payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_MEAN_LD: begin
                r_div_dq   <= {w_total_mag, FRAC_W'(0)};
                r_div_dvs  <= DVS_W'(r_count);
                r_div_rem  <= '0;
                r_div_neg  <= r_total[TOTAL_W-1];
                r_zero_cnt <= (r_count == '0);
            end
            S_MEAN_DIV, S_AVG_DIV, S_RATIO_DIV: begin
                r_div_dq  <= n_div_dq;
                r_div_rem <= n_div_rem;
            end
            S_MEAN_SAT: begin
                r_mean <= r_zero_cnt ? '0 : w_mean_sat;
            end
            S_AVG_LD: begin
                r_div_dq  <= DVD_W'(w_wtotal_mag);
                r_div_dvs <= DVS_W'(w_period);
                r_div_rem <= '0;
                r_div_neg <= r_wtotal[WTOT_W-1];
            end
            S_RATIO_LD: begin
                // window mean magnitude is the quotient; its sign is the total's
                r_div_dq  <= {w_mean_mag, FRAC_W'(0)};
                r_div_dvs <= w_q_low;
                r_div_rem <= '0;
                r_div_neg <= r_mean[MEAN_W-1] ^ r_div_neg;
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_conv <= (r_run == RUN_W'(w_period));
                    r_out_coef <= r_ratio;
                    r_out_mean <= r_mean;
                end
            end
            default: begin
            end
        endcase
    end

    // checks
    `MACD_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= w_period, "window fill above period")
    `MACD_ASSERT(a_head_bound, i_clk, i_rst_n, PW'(r_head) < w_period, "window head out of ring")
    `MACD_ASSERT_IMP(a_div_cnt_state, i_clk, i_rst_n, r_div_cnt != '0,
        (r_state == S_MEAN_DIV) || (r_state == S_AVG_DIV) || (r_state == S_RATIO_DIV),
        "divider count live outside a divide pass")
    `MACD_ASSERT_IMP(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state) == S_DONE, "result raised outside the done state")
    `MACD_ASSERT_NXT(a_last_stalls, i_clk, i_rst_n, w_in_xfer && i_s_axis_tlast,
        !o_s_axis_tready, "input still ready after a closing gene")

endmodule
